/* sv/cfsg_pkg.sv */
// Shared types, codes and limits of the clipped fill span generator.
// Used by cfsg_alu, cfsg_clip and clipped_fill_span_generator; depends on nothing.
package cfsg_pkg;

    localparam int MAX_PITCH  = 1024;
    localparam int MAX_ROWS   = 64;
    localparam int COLOR_BITS = 16;

    localparam logic [15:0] COLOR_MASK = 16'((64'd1 << COLOR_BITS) - 64'd1);

    typedef enum logic [1:0] {
        MODE_PIXEL  = 2'd0,
        MODE_RECT   = 2'd1,
        MODE_LARROW = 2'd2,
        MODE_RARROW = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_WIN_LEFT   = 3'd0,
        REG_WIN_TOP    = 3'd1,
        REG_WIN_WIDTH  = 3'd2,
        REG_WIN_HEIGHT = 3'd3,
        REG_LINE_PITCH = 3'd4
    } t_reg_idx;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_MUL = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [15:0] a;
        logic [15:0] b;
        logic        cin;
    } t_alu_req;

    typedef struct packed {
        logic [9:0]  left;
        logic [5:0]  top;
        logic [10:0] width;
        logic [6:0]  height;
        logic [10:0] pitch;
    } t_win;

    typedef struct packed {
        logic [1:0]  mode;
        logic [10:0] x_pos;
        logic [10:0] y_pos;
        logic [11:0] rect_width;
        logic [11:0] rect_height;
        logic [11:0] arrow_size;
        logic [15:0] color;
    } t_cmd;

    typedef struct packed {
        logic load;
        logic clamp;
        logic cut;
    } t_clip_ctl;

    typedef struct packed {
        logic        empty;
        logic        arrow;
        logic        left;
        logic [6:0]  rows;
        logic [10:0] len;
        logic [10:0] col0;
        logic [5:0]  s;
        logic        up;
        logic [6:0]  row0;
        logic [15:0] color;
    } t_plan;

endpackage

/* sv/cfsg_alu.sv */
// Shared arithmetic unit: 16-bit add with carry-in, or 11x7 multiply.
// Depends on cfsg_pkg.
module cfsg_alu (
    input  cfsg_pkg::t_alu_req i_req,
    output logic [15:0]        o_res
);

    // only the low 16 bits of the product are kept: addresses wrap at 2^16
    logic [15:0] prod;

    assign prod = 16'(i_req.a[10:0]) * 16'(i_req.b[6:0]);

    always_comb begin
        unique case (i_req.op)
            cfsg_pkg::ALU_MUL: o_res = prod;
            cfsg_pkg::ALU_ADD: o_res = i_req.a + i_req.b + {15'd0, i_req.cin};
            default:           o_res = '0;
        endcase
    end

endmodule

/* sv/cfsg_clip.sv */
// Command clipper: holds the request, clamps its position, then cuts it to the window.
// Produces the per-command row plan; depends on cfsg_pkg.
module cfsg_clip (
    input  logic                i_clk,
    input  cfsg_pkg::t_clip_ctl i_ctl,
    input  cfsg_pkg::t_cmd      i_cmd,
    input  cfsg_pkg::t_win      i_win,
    output cfsg_pkg::t_plan     o_plan
);

    cfsg_pkg::t_cmd  r_cmd;
    cfsg_pkg::t_plan r_plan, n_plan;
    logic [9:0]  r_xc, n_xc;
    logic [5:0]  r_yc, n_yc;
    logic [10:0] r_w_eff, w_eff;
    logic [6:0]  r_h_eff, h_eff;
    logic        r_pix_ok, n_pix_ok;

    // clamp stage
    logic signed [11:0] x_ext, y_ext, w_s, h_s;

    always_comb begin
        if (i_win.width == 11'd0) begin
            w_eff = 11'd1;
        end else if (i_win.width > 11'(cfsg_pkg::MAX_PITCH)) begin
            w_eff = 11'(cfsg_pkg::MAX_PITCH);
        end else begin
            w_eff = i_win.width;
        end
        if (i_win.height == 7'd0) begin
            h_eff = 7'd1;
        end else if (i_win.height > 7'(cfsg_pkg::MAX_ROWS)) begin
            h_eff = 7'(cfsg_pkg::MAX_ROWS);
        end else begin
            h_eff = i_win.height;
        end
    end

    assign x_ext = {r_cmd.x_pos[10], r_cmd.x_pos};
    assign y_ext = {r_cmd.y_pos[10], r_cmd.y_pos};
    assign w_s   = {1'b0, w_eff};
    assign h_s   = {5'b0, h_eff};

    always_comb begin
        priority if (x_ext < 12'sd0) begin
            n_xc = '0;
        end else if (x_ext >= w_s) begin
            n_xc = 10'(w_eff - 11'd1);
        end else begin
            n_xc = x_ext[9:0];
        end
        priority if (y_ext < 12'sd0) begin
            n_yc = '0;
        end else if (y_ext >= h_s) begin
            n_yc = 6'(h_eff - 7'd1);
        end else begin
            n_yc = y_ext[5:0];
        end
        n_pix_ok = (x_ext >= 12'sd0) && (x_ext < w_s) && (y_ext >= 12'sd0) && (y_ext < h_s);
    end

    // cut stage
    logic signed [12:0] xw, yh;
    logic [10:0] w_room;
    logic [6:0]  h_room;
    logic        w_cut, h_cut, w_ok, h_ok;
    logic [11:0] xh, size1;
    logic [12:0] ys;
    logic        ax_cut, ay_cut;
    logic [6:0]  size2;
    logic [5:0]  s;

    always_comb begin
        xw     = $signed({3'b0, r_xc}) + $signed({r_cmd.rect_width[11], r_cmd.rect_width});
        yh     = $signed({7'b0, r_yc}) + $signed({r_cmd.rect_height[11], r_cmd.rect_height});
        w_room = r_w_eff - {1'b0, r_xc};
        h_room = r_h_eff - {1'b0, r_yc};
        w_cut  = xw > $signed({2'b0, r_w_eff});
        h_cut  = yh > $signed({6'b0, r_h_eff});
        w_ok   = w_cut || (!r_cmd.rect_width[11] && (r_cmd.rect_width != 12'd0));
        h_ok   = h_cut || (!r_cmd.rect_height[11] && (r_cmd.rect_height != 12'd0));

        // arrow: cut the half size at the right edge, then the size at the bottom
        xh     = {2'b0, r_xc} + {1'b0, r_cmd.arrow_size[11:1]};
        ax_cut = xh > {1'b0, r_w_eff};
        size1  = ax_cut ? {w_room, 1'b0} : r_cmd.arrow_size;
        ys     = {7'b0, r_yc} + {1'b0, size1};
        ay_cut = ys > {6'b0, r_h_eff};
        size2  = ay_cut ? h_room : size1[6:0];
        s      = size2[6:1];
    end

    always_comb begin
        n_plan       = '0;
        n_plan.s     = s;
        n_plan.row0  = {1'b0, i_win.top} + {1'b0, r_yc};
        n_plan.color = r_cmd.color;
        n_plan.col0  = {1'b0, r_xc};
        unique case (r_cmd.mode)
            cfsg_pkg::MODE_PIXEL: begin
                n_plan.empty = !r_pix_ok;
                n_plan.rows  = 7'd1;
                n_plan.len   = 11'd1;
            end
            cfsg_pkg::MODE_RECT: begin
                n_plan.empty = !(w_ok && h_ok);
                n_plan.rows  = h_cut ? h_room : r_cmd.rect_height[6:0];
                n_plan.len   = w_cut ? w_room : r_cmd.rect_width[10:0];
            end
            cfsg_pkg::MODE_LARROW: begin
                n_plan.empty = (s == 6'd0);
                n_plan.arrow = 1'b1;
                n_plan.left  = 1'b1;
                n_plan.rows  = {s, 1'b0} - 7'd1;
                n_plan.len   = 11'd1;
                n_plan.col0  = {1'b0, r_xc} + {5'b0, s} - 11'd1;
                n_plan.up    = (s > 6'd1);
            end
            cfsg_pkg::MODE_RARROW: begin
                n_plan.empty = (s == 6'd0);
                n_plan.arrow = 1'b1;
                n_plan.rows  = {s, 1'b0};
                n_plan.len   = 11'd0;
                n_plan.up    = (s != 6'd0);
            end
            default: n_plan.empty = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
        end
        if (i_ctl.clamp) begin
            r_xc     <= n_xc;
            r_yc     <= n_yc;
            r_w_eff  <= w_eff;
            r_h_eff  <= h_eff;
            r_pix_ok <= n_pix_ok;
        end
        if (i_ctl.cut) begin
            r_plan <= n_plan;
        end
    end

    assign o_plan = r_plan;

endmodule

/* sv/clipped_fill_span_generator.sv */
// Top level of the clipped fill span generator: register port, sequencer, output register.
// Depends on cfsg_pkg, cfsg_clip and cfsg_alu.
//
// Use: a draw request (pixel, rectangle, left or right arrow) enters on the
// i_valid / o_stall channel and is taken at an edge with i_valid high and
// o_stall low. It is clipped to the window set through the APB-style port and
// turned into one span per framebuffer row on the o_valid / i_stall channel;
// o_span_last marks the final span of a request. Rows with an empty span and
// requests clipped away entirely emit nothing.
// Sequence: after acceptance the request passes through set-up (clamp, cut,
// multiply, two address adds, pitch-minus-one), then walks one row per cycle
// while the output is not stalled. A right arrow's first row is empty and
// emits no span. A request walks at most 64 rows; an empty request returns
// the block to idle straight from the multiply step.
// Every address step goes through the one shared adder, which sets the row rate.
// o_stall is high for the whole of a request's set-up and row walk.
// A stall on the output holds the span register; the row walk waits on it but
// the block takes the next request as soon as the walk of the last row is done.
// Reset (synchronous, active low) returns the sequencer to idle, drops any
// pending span and restores the window to the full 1024 x 64 framebuffer.
// Configuration is to be written only while the block is idle.
module clipped_fill_span_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic signed [10:0] i_x_pos,
    input  logic signed [10:0] i_y_pos,
    input  logic signed [11:0] i_rect_width,
    input  logic signed [11:0] i_rect_height,
    input  logic [11:0] i_arrow_size,
    input  logic [15:0] i_fill_color,
    // span channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_span_address,
    output logic [10:0] o_span_length,
    output logic [15:0] o_span_color,
    output logic        o_span_last
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLAMP = 8'b0000_0010,
        S_CUT   = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_ADDL  = 8'b0001_0000,
        S_ADDC  = 8'b0010_0000,
        S_PM1   = 8'b0100_0000,
        S_ROW   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    cfsg_pkg::t_win      r_win;
    cfsg_pkg::t_cmd      cmd;
    cfsg_pkg::t_plan     plan;
    cfsg_pkg::t_clip_ctl clip_ctl;
    cfsg_pkg::t_alu_req  alu_req;
    logic [15:0]         alu_res;

    logic [15:0] r_acc;
    logic [15:0] r_pm1;
    logic [10:0] r_len;
    logic [6:0]  r_rows;
    logic        r_up;

    logic        r_out_valid;
    logic [15:0] r_out_addr;
    logic [10:0] r_out_len;
    logic [15:0] r_out_color;
    logic        r_out_last;

    logic cfg_write, cmd_accept, row_go, advance, load_out;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= 10'd0;
            r_win.top    <= 6'd0;
            r_win.width  <= 11'd1024;
            r_win.height <= 7'd64;
            r_win.pitch  <= 11'd1024;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                cfsg_pkg::REG_WIN_LEFT:   r_win.left   <= pwdata[9:0];
                cfsg_pkg::REG_WIN_TOP:    r_win.top    <= pwdata[5:0];
                cfsg_pkg::REG_WIN_WIDTH:  r_win.width  <= pwdata[10:0];
                cfsg_pkg::REG_WIN_HEIGHT: r_win.height <= pwdata[6:0];
                cfsg_pkg::REG_LINE_PITCH: r_win.pitch  <= pwdata[10:0];
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            cfsg_pkg::REG_WIN_LEFT:   prdata = {22'd0, r_win.left};
            cfsg_pkg::REG_WIN_TOP:    prdata = {26'd0, r_win.top};
            cfsg_pkg::REG_WIN_WIDTH:  prdata = {21'd0, r_win.width};
            cfsg_pkg::REG_WIN_HEIGHT: prdata = {25'd0, r_win.height};
            cfsg_pkg::REG_LINE_PITCH: prdata = {21'd0, r_win.pitch};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- request intake and clipping ----------------
    assign o_stall    = (r_state != S_IDLE);
    assign cmd_accept = i_valid && !o_stall;

    always_comb begin
        cmd.mode        = i_mode;
        cmd.x_pos       = i_x_pos;
        cmd.y_pos       = i_y_pos;
        cmd.rect_width  = i_rect_width;
        cmd.rect_height = i_rect_height;
        cmd.arrow_size  = i_arrow_size;
        cmd.color       = i_fill_color & cfsg_pkg::COLOR_MASK;
    end

    cfsg_clip u_clip (
        .i_clk  (i_clk),
        .i_ctl  (clip_ctl),
        .i_cmd  (cmd),
        .i_win  (r_win),
        .o_plan (plan)
    );

    cfsg_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // A row with no pixels needs no output slot; otherwise wait for the span
    // register to be free or to drain this cycle.
    assign row_go = (r_len == 11'd0) || !r_out_valid || !i_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        clip_ctl = '0;
        alu_req  = '{op: cfsg_pkg::ALU_ADD, a: 16'd0, b: 16'd0, cin: 1'b0};
        advance  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_accept) begin
                    clip_ctl.load = 1'b1;
                    n_state       = S_CLAMP;
                end
            end
            S_CLAMP: begin
                clip_ctl.clamp = 1'b1;
                n_state        = S_CUT;
            end
            S_CUT: begin
                clip_ctl.cut = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                // row base: pitch times the first framebuffer row
                alu_req = '{op: cfsg_pkg::ALU_MUL, a: {5'd0, r_win.pitch},
                            b: {9'd0, plan.row0}, cin: 1'b0};
                n_state = plan.empty ? S_IDLE : S_ADDL;
            end
            S_ADDL: begin
                alu_req = '{op: cfsg_pkg::ALU_ADD, a: r_acc, b: {6'd0, r_win.left}, cin: 1'b0};
                n_state = S_ADDC;
            end
            S_ADDC: begin
                alu_req = '{op: cfsg_pkg::ALU_ADD, a: r_acc, b: {5'd0, plan.col0}, cin: 1'b0};
                n_state = S_PM1;
            end
            S_PM1: begin
                alu_req = '{op: cfsg_pkg::ALU_ADD, a: {5'd0, r_win.pitch}, b: 16'hFFFF,
                            cin: 1'b0};
                n_state = S_ROW;
            end
            S_ROW: begin
                // step to the next row: a left arrow also moves one column,
                // left while growing and right while shrinking
                if (plan.left && r_up) begin
                    alu_req = '{op: cfsg_pkg::ALU_ADD, a: r_acc, b: r_pm1, cin: 1'b0};
                end else begin
                    alu_req = '{op: cfsg_pkg::ALU_ADD, a: r_acc, b: {5'd0, r_win.pitch},
                                cin: plan.left};
                end
                if (row_go) begin
                    advance  = 1'b1;
                    load_out = (r_len != 11'd0);
                    if (r_rows == 7'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- row walk datapath ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_acc  <= alu_res;
            r_len  <= plan.len;
            r_rows <= plan.rows;
            r_up   <= plan.up;
        end
        if ((r_state == S_ADDL) || (r_state == S_ADDC)) begin
            r_acc <= alu_res;
        end
        if (r_state == S_PM1) begin
            r_pm1 <= alu_res;
        end
        if (advance) begin
            r_acc  <= alu_res;
            r_rows <= r_rows - 7'd1;
            if (plan.arrow) begin
                // grow up to the half size, then shrink back to one
                r_len <= r_up ? (r_len + 11'd1) : (r_len - 11'd1);
                r_up  <= r_up && (({1'b0, r_len} + 12'd1) < {6'd0, plan.s});
            end
        end
        if (load_out) begin
            r_out_addr  <= r_acc;
            r_out_len   <= r_len;
            r_out_color <= plan.color;
            r_out_last  <= (r_rows == 7'd1);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_span_address = r_out_addr;
    assign o_span_length  = r_out_len;
    assign o_span_color   = r_out_color;
    assign o_span_last    = r_out_last;

    // ---------------- assertions ----------------
    a_rows_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> ((r_rows != 7'd0) && (r_rows <= 7'(cfsg_pkg::MAX_ROWS))))
        else $error("row count out of range during row walk");

    a_span_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (r_len != 11'd0))
        else $error("span loaded with zero length");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && (r_rows == 7'd1)) |=> (r_state == S_IDLE) && o_span_last)
        else $error("last span did not end the request");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || !i_stall))
        else $error("pending span overwritten");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_accept |=> (r_state == S_CLAMP))
        else $error("accepted request did not start set-up");

endmodule
